@@ rtl/wmms_pkg.sv @@
// Shared types and constants for the windowed min/max/mean statistics block.
// Holds the queue word that the front end hands to the back end.
// No dependencies.
package wmms_pkg;

  localparam int NIN       = 6;
  localparam int VAL_W     = 16;
  localparam int SUM_W     = 20;
  localparam int CNT_W     = 5;
  localparam int PERIOD_W  = 5;
  localparam int ELAPSED_W = 7;
  localparam int QDEPTH    = 2;

  localparam int TEMP_W  = 11;
  localparam int HUM_W   = 11;
  localparam int WDIR_W  = 13;
  localparam int RAIN_W  = 10;
  localparam int WSPD_W  = 10;
  localparam int LIGHT_W = 15;

  localparam logic [PERIOD_W-1:0] PERIOD_MIN = 5'd5;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 5'd20;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 5'd5;
  localparam int                  PERIOD_SPAN = 16;

  localparam logic signed [TEMP_W-1:0] COLD_LIMIT  = 11'sd160;
  localparam logic        [HUM_W-1:0]  HUMID_LIMIT = 11'd1280;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic [NIN-1:0][VAL_W-1:0] sample;
    logic                      reload;
    logic                      close;
    logic [CNT_W-1:0]          count;
    logic                      alert;
  } job_t;

endpackage

@@ rtl/windowed_min_max_mean_stats.sv @@
// Windowed min/max/mean statistics over six weather channels.
// A status word is registered in the output register once its sample word has passed the queue and the status state.
// The back end takes one queued word at a time; a window-closing word also runs the
// shared mean divider, one quotient bit per cycle, once per channel.
// A two-entry queue keeps accepting sample words while results wait, until it is full.
// Synchronous active-low reset: period 5, window position zero, queue and outputs empty.
module windowed_min_max_mean_stats #(
  parameter int NUM_CHANNELS   = 6,
  parameter int WINDOW_SECONDS = 60,
  parameter int SAMPLE_WIDTH   = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [wmms_pkg::TEMP_W-1:0]   in_temperature_sample,
  input  logic        [wmms_pkg::HUM_W-1:0]    in_humidity_sample,
  input  logic signed [wmms_pkg::WDIR_W-1:0]   in_wind_direction_sample,
  input  logic        [wmms_pkg::RAIN_W-1:0]   in_rainfall_sample,
  input  logic        [wmms_pkg::WSPD_W-1:0]   in_wind_speed_sample,
  input  logic        [wmms_pkg::LIGHT_W-1:0]  in_light_sample,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [wmms_pkg::PERIOD_W-1:0] cfg_period_seconds,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_kind,
  output logic [2:0]                           out_channel,
  output logic signed [SAMPLE_WIDTH-1:0]       out_window_minimum,
  output logic signed [SAMPLE_WIDTH-1:0]       out_window_mean,
  output logic signed [SAMPLE_WIDTH-1:0]       out_window_maximum,
  output logic                                 out_cold_humid_alert,
  output logic                                 out_last
);
  import wmms_pkg::*;

  logic push, pop, q_full, q_empty;
  job_t job_in, job_out;

  wmms_front #(
    .WINDOW_SECONDS (WINDOW_SECONDS)
  ) u_front (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_temperature_sample    (in_temperature_sample),
    .in_humidity_sample       (in_humidity_sample),
    .in_wind_direction_sample (in_wind_direction_sample),
    .in_rainfall_sample       (in_rainfall_sample),
    .in_wind_speed_sample     (in_wind_speed_sample),
    .in_light_sample          (in_light_sample),
    .cfg_valid                (cfg_valid),
    .cfg_ready                (cfg_ready),
    .cfg_period_seconds       (cfg_period_seconds),
    .push                     (push),
    .job                      (job_in),
    .q_full                   (q_full)
  );

  wmms_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (job_in),
    .full  (q_full),
    .pop   (pop),
    .rdata (job_out),
    .empty (q_empty)
  );

  wmms_back #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_empty              (q_empty),
    .q_data               (job_out),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_kind             (out_kind),
    .out_channel          (out_channel),
    .out_window_minimum   (out_window_minimum),
    .out_window_mean      (out_window_mean),
    .out_window_maximum   (out_window_maximum),
    .out_cold_humid_alert (out_cold_humid_alert),
    .out_last             (out_last)
  );

endmodule

@@ rtl/wmms_front.sv @@
// Front end: accepts sample words, holds the period register and the window
// position, and classifies each word into a queue entry. Uses wmms_pkg.
module wmms_front #(
  parameter int WINDOW_SECONDS = 60
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [wmms_pkg::TEMP_W-1:0]     in_temperature_sample,
  input  logic        [wmms_pkg::HUM_W-1:0]      in_humidity_sample,
  input  logic signed [wmms_pkg::WDIR_W-1:0]     in_wind_direction_sample,
  input  logic        [wmms_pkg::RAIN_W-1:0]     in_rainfall_sample,
  input  logic        [wmms_pkg::WSPD_W-1:0]     in_wind_speed_sample,
  input  logic        [wmms_pkg::LIGHT_W-1:0]    in_light_sample,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [wmms_pkg::PERIOD_W-1:0]   cfg_period_seconds,
  output logic                                   push,
  output wmms_pkg::job_t                         job,
  input  logic                                   q_full
);
  import wmms_pkg::*;

  logic [PERIOD_W-1:0]  period_r;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [PERIOD_W-1:0]  per_c;
  logic [ELAPSED_W:0]   next_sec, next_end;
  logic                 close_c;
  logic [3:0]           cnt_idx;
  logic [CNT_W-1:0]     cnt_tab [PERIOD_SPAN];

  for (genvar g = 0; g < PERIOD_SPAN; g++) begin : g_cnt
    localparam int CV = WINDOW_SECONDS / (g + 5);
    assign cnt_tab[g] = CNT_W'(CV);
  end

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign push      = in_valid && !q_full;

  always_comb begin
    if (period_r < PERIOD_MIN) begin
      per_c = PERIOD_MIN;
    end else if (period_r > PERIOD_MAX) begin
      per_c = PERIOD_MAX;
    end else begin
      per_c = period_r;
    end
    cnt_idx  = 4'(per_c - PERIOD_MIN);
    next_sec = {1'b0, elapsed_r} + (ELAPSED_W+1)'(per_c);
    next_end = next_sec + (ELAPSED_W+1)'(per_c);
    close_c  = next_end > (ELAPSED_W+1)'(WINDOW_SECONDS);
    elapsed_nxt = elapsed_r;
    if (push) begin
      elapsed_nxt = close_c ? '0 : next_sec[ELAPSED_W-1:0];
    end
  end

  always_comb begin
    job.sample[0] = VAL_W'(in_temperature_sample);
    job.sample[1] = VAL_W'(in_humidity_sample);
    job.sample[2] = VAL_W'(in_wind_direction_sample);
    job.sample[3] = VAL_W'(in_rainfall_sample);
    job.sample[4] = VAL_W'(in_wind_speed_sample);
    job.sample[5] = VAL_W'(in_light_sample);
    job.reload    = (elapsed_r == '0);
    job.close     = close_c;
    job.count     = cnt_tab[cnt_idx];
    job.alert     = (in_temperature_sample < COLD_LIMIT) &&
                    (in_humidity_sample > HUMID_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= PERIOD_RST;
      elapsed_r <= '0;
    end else begin
      if (cfg_valid) begin
        period_r <= cfg_period_seconds;
      end
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule

@@ rtl/wmms_fifo.sv @@
// Two-entry queue of classified words between the front and back ends.
// Uses wmms_pkg for the entry type.
module wmms_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wmms_pkg::job_t wdata,
  output logic           full,
  input  logic           pop,
  output wmms_pkg::job_t rdata,
  output logic           empty
);
  import wmms_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  job_t             mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   cnt_r;

  assign full  = (cnt_r == (PTR_W+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("Queue written while full.");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("Queue read while empty.");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PTR_W+1)'(QDEPTH))
    else $error("Queue fill count out of range.");

endmodule

@@ rtl/wmms_div.sv @@
// Shared iterative divider for the window mean: signed sum by unsigned count,
// one quotient bit per cycle, truncated toward zero. Uses wmms_pkg.
module wmms_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [wmms_pkg::SUM_W-1:0] dividend,
  input  logic        [wmms_pkg::CNT_W-1:0] divisor,
  output logic                              busy,
  output logic                              done,
  output logic signed [wmms_pkg::SUM_W-1:0] quotient
);
  import wmms_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  a_r;
  logic [CNT_W-1:0]  rem_r, d_r;
  logic [STEP_W-1:0] step_r;
  logic              neg_r, busy_r, done_r;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign trial    = {rem_r, a_r[SUM_W-1]};
  assign fits     = trial >= {1'b0, d_r};
  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = neg_r ? -$signed(a_r) : $signed(a_r);

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      neg_r <= dividend[SUM_W-1];
      d_r   <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? CNT_W'(trial - {1'b0, d_r}) : trial[CNT_W-1:0];
      a_r   <= {a_r[SUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= STEP_W'(SUM_W);
    end else if (busy_r) begin
      step_r <= step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/wmms_back.sv @@
// Back end: pops classified words, updates the per-channel trackers, and
// sequences the status word and the window statistics words through the
// output register. Uses wmms_pkg and wmms_div.
module wmms_back #(
  parameter int NUM_CHANNELS = 6,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  wmms_pkg::job_t                q_data,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_kind,
  output logic [2:0]                    out_channel,
  output logic signed [SAMPLE_WIDTH-1:0] out_window_minimum,
  output logic signed [SAMPLE_WIDTH-1:0] out_window_mean,
  output logic signed [SAMPLE_WIDTH-1:0] out_window_maximum,
  output logic                          out_cold_humid_alert,
  output logic                          out_last
);
  import wmms_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_STATUS = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic signed [63:0] MEAN_HI = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] MEAN_LO = -MEAN_HI - 64'sd1;

  logic [1:0]       state_r, state_nxt;
  logic [CH_W-1:0]  ch_r, ch_nxt, start_idx;
  logic             close_r, close_nxt, alert_r, alert_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic signed [VAL_W-1:0] min_r [NUM_CHANNELS];
  logic signed [VAL_W-1:0] max_r [NUM_CHANNELS];
  logic signed [SUM_W-1:0] sum_r [NUM_CHANNELS];
  logic signed [VAL_W-1:0] ch_smp  [NUM_CHANNELS];
  logic signed [VAL_W-1:0] min_upd [NUM_CHANNELS];
  logic signed [VAL_W-1:0] max_upd [NUM_CHANNELS];
  logic signed [SUM_W-1:0] sum_upd [NUM_CHANNELS];

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_kind_r, out_kind_nxt;
  logic [2:0]                    out_channel_r, out_channel_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_min_r, out_min_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_mean_r, out_mean_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_max_r, out_max_nxt;
  logic                          out_alert_r, out_alert_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                    slot_free, last_ch;
  logic                    div_start, div_busy, div_done;
  logic signed [SUM_W-1:0] div_quot;
  logic signed [63:0]      quot_ext, mean_sat;

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_ch
    logic signed [SUM_W:0] acc;
    if (g < NIN) begin : g_live
      assign ch_smp[g] = $signed(q_data.sample[g]);
    end else begin : g_zero
      assign ch_smp[g] = '0;
    end
    assign acc = (SUM_W+1)'(sum_r[g]) + (SUM_W+1)'(ch_smp[g]);
    assign sum_upd[g] = q_data.reload ? SUM_W'(ch_smp[g]) :
                        (acc[SUM_W] != acc[SUM_W-1]) ?
                        (acc[SUM_W] ? SUM_MIN : SUM_MAX) : acc[SUM_W-1:0];
    assign min_upd[g] = (q_data.reload || ch_smp[g] < min_r[g]) ? ch_smp[g] : min_r[g];
    assign max_upd[g] = (q_data.reload || ch_smp[g] > max_r[g]) ? ch_smp[g] : max_r[g];
  end

  wmms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r[start_idx]),
    .divisor  (cnt_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign slot_free = !out_valid_r || !out_stall;
  assign last_ch   = (ch_r == CH_W'(NUM_CHANNELS - 1));
  assign quot_ext  = 64'(div_quot);

  always_comb begin
    if (quot_ext > MEAN_HI) begin
      mean_sat = MEAN_HI;
    end else if (quot_ext < MEAN_LO) begin
      mean_sat = MEAN_LO;
    end else begin
      mean_sat = quot_ext;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    ch_nxt          = ch_r;
    close_nxt       = close_r;
    alert_nxt       = alert_r;
    cnt_nxt         = cnt_r;
    pop             = 1'b0;
    div_start       = 1'b0;
    start_idx       = '0;
    out_valid_nxt   = out_valid_r && out_stall;
    out_kind_nxt    = out_kind_r;
    out_channel_nxt = out_channel_r;
    out_min_nxt     = out_min_r;
    out_mean_nxt    = out_mean_r;
    out_max_nxt     = out_max_r;
    out_alert_nxt   = out_alert_r;
    out_last_nxt    = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          close_nxt = q_data.close;
          alert_nxt = q_data.alert;
          cnt_nxt   = q_data.count;
          state_nxt = ST_STATUS;
        end
      end
      ST_STATUS: begin
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = 1'b0;
          out_channel_nxt = '0;
          out_min_nxt     = '0;
          out_mean_nxt    = '0;
          out_max_nxt     = '0;
          out_alert_nxt   = alert_r;
          out_last_nxt    = !close_r;
          if (close_r) begin
            div_start = 1'b1;
            ch_nxt    = '0;
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DIV: begin
        if (div_done && slot_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = 1'b1;
          out_channel_nxt = 3'(ch_r);
          out_min_nxt     = SAMPLE_WIDTH'(64'(min_r[ch_r]));
          out_mean_nxt    = mean_sat[SAMPLE_WIDTH-1:0];
          out_max_nxt     = SAMPLE_WIDTH'(64'(max_r[ch_r]));
          out_alert_nxt   = 1'b0;
          out_last_nxt    = last_ch;
          if (last_ch) begin
            state_nxt = ST_IDLE;
          end else begin
            ch_nxt    = ch_r + 1'b1;
            start_idx = ch_r + 1'b1;
            div_start = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        min_r[i] <= min_upd[i];
        max_r[i] <= max_upd[i];
        sum_r[i] <= sum_upd[i];
      end
    end
    ch_r          <= ch_nxt;
    close_r       <= close_nxt;
    alert_r       <= alert_nxt;
    cnt_r         <= cnt_nxt;
    out_kind_r    <= out_kind_nxt;
    out_channel_r <= out_channel_nxt;
    out_min_r     <= out_min_nxt;
    out_mean_r    <= out_mean_nxt;
    out_max_r     <= out_max_nxt;
    out_alert_r   <= out_alert_nxt;
    out_last_r    <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_kind             = out_kind_r;
  assign out_channel          = out_channel_r;
  assign out_window_minimum   = out_min_r;
  assign out_window_mean      = out_mean_r;
  assign out_window_maximum   = out_max_r;
  assign out_cold_humid_alert = out_alert_r;
  assign out_last             = out_last_r;

  a_div_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("Divider started while busy.");

  a_div_only_on_close: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> close_r)
    else $error("Statistics sequence without a window close.");

  a_status_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_kind_r) |->
      (out_channel_r == '0 && out_min_r == '0 && out_mean_r == '0 && out_max_r == '0))
    else $error("Status word carries statistics fields.");

endmodule
